### rtl/core/hpt_pkg.sv
// Shared types and constants of the homogeneous point transform core.
package hpt_pkg;

  // Fixed-point format of coordinates and coefficients
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 32;

  // Product, row-sum and dividend widths
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int TRANS_WIDTH = COEF_WIDTH + FRAC_BITS;
  localparam int SUM_WIDTH   = ((PROD_WIDTH > TRANS_WIDTH) ? PROD_WIDTH : TRANS_WIDTH) + 2;
  localparam int DVD_WIDTH   = COORD_WIDTH + FRAC_BITS;

  // Divide threshold: |w| must exceed floor(0.0001 * 2^FRAC_BITS) to trigger the divide
  localparam int W_MIN_RAW = (1 << FRAC_BITS) / 10000;

  // Register file
  localparam int NUM_REGS   = 8;
  localparam int ADDR_WIDTH = 6;

  // Command codes
  localparam logic CMD_POINT     = 1'b0;
  localparam logic CMD_DIRECTION = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } hpt_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divided;
    logic               saturated;
  } hpt_result_t;

  // One finished row sum
  typedef struct packed {
    logic                          valid;
    logic                          sat;
    logic signed [COORD_WIDTH-1:0] value;
  } hpt_row_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] res_x;
    logic signed [COORD_WIDTH-1:0] res_y;
    logic signed [COORD_WIDTH-1:0] res_z;
    logic [2:0]                    neg;
    logic                          divided;
    logic                          sat;
  } hpt_side_t;

endpackage

### rtl/core/homogeneous_point_transform_core.sv
// Top level of the homogeneous point transform core: registers, row sums, divide, output.
//
// Takes one item per cycle whenever start is high; busy is always low. Each item gives one
// result, marked by done for one cycle, after passing through multiply/add in the row-sum
// units, a register that prepares the divide, the divider stages (one quotient bit each)
// and the output register. Direction items flow through the same pipeline with equal
// latency, so results leave in order. The matrix must only be written while no item is in
// flight.
module homogeneous_point_transform_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  hpt_pkg::hpt_item_t                item,
  output logic                              done,
  output hpt_pkg::hpt_result_t              result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpt_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  localparam int CW = hpt_pkg::COORD_WIDTH;
  localparam int DW = hpt_pkg::DVD_WIDTH;
  localparam int FB = hpt_pkg::FRAC_BITS;

  localparam logic [63:0] RESET_REGS [hpt_pkg::NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };
  localparam logic signed [CW-1:0] W_MIN  = CW'(hpt_pkg::W_MIN_RAW);
  localparam logic signed [CW-1:0] SAT_HI = CW'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);
  localparam logic [DW-1:0]        Q_HI   = DW'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic [DW-1:0]        Q_LO   = DW'(64'(1) << (CW - 1));

  logic [63:0] regs [hpt_pkg::NUM_REGS];
  logic        accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        regs[i] <= RESET_REGS[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      regs[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = regs[paddr[5:3]];

  // Coordinates taken from the low COORD_WIDTH bits
  logic signed [CW-1:0] v [3];
  logic                 translate;
  assign v[0]      = item.coord_x[CW-1:0];
  assign v[1]      = item.coord_y[CW-1:0];
  assign v[2]      = item.coord_z[CW-1:0];
  assign translate = (item.command == hpt_pkg::CMD_POINT);

  // Row sums
  hpt_pkg::hpt_row_t row [4];
  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [hpt_pkg::COEF_WIDTH-1:0] coef [4];
    always_comb begin
      coef[0] = regs[2*r][31:0];
      coef[1] = regs[2*r][63:32];
      coef[2] = regs[2*r+1][31:0];
      coef[3] = regs[2*r+1][63:32];
    end
    hpt_rowsum u_row (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (accept),
      .translate ((r == 3) ? 1'b1 : translate),
      .coef      (coef),
      .v         (v),
      .row       (row[r])
    );
  end

  // Command delay matching the row-sum latency
  logic [3:0] dir_line;
  always_ff @(posedge clk) begin
    dir_line <= {dir_line[2:0], (item.command == hpt_pkg::CMD_DIRECTION)};
  end

  // Divide preparation
  logic               is_point, do_div;
  logic [CW-1:0]      w_mag;
  logic [DW-1:0]      dvd_n [3];
  hpt_pkg::hpt_side_t side_n;
  always_comb begin
    is_point = !dir_line[3];
    do_div   = is_point && ((row[3].value > W_MIN) || (row[3].value < -W_MIN));
    w_mag    = row[3].value[CW-1] ? CW'(-row[3].value) : row[3].value;
    for (int l = 0; l < 3; l++) begin
      // Magnitude is unsigned, so the most negative value widens without sign fill
      dvd_n[l] = DW'($unsigned(row[l].value[CW-1] ? CW'(-row[l].value) : row[l].value)) << FB;
      side_n.neg[l] = row[l].value[CW-1] ^ row[3].value[CW-1];
    end
    side_n.res_x   = row[0].value;
    side_n.res_y   = row[1].value;
    side_n.res_z   = row[2].value;
    side_n.divided = do_div;
    side_n.sat     = row[0].sat || row[1].sat || row[2].sat || (is_point && row[3].sat);
  end

  logic               div_valid;
  logic [DW-1:0]      div_dvd [3];
  logic [CW-1:0]      div_dsr;
  hpt_pkg::hpt_side_t div_side;
  always_ff @(posedge clk) begin
    div_dvd  <= dvd_n;
    div_dsr  <= w_mag;
    div_side <= side_n;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else begin
      div_valid <= row[0].valid;
    end
  end

  // Divider
  logic               q_valid;
  logic [DW-1:0]      quo [3];
  hpt_pkg::hpt_side_t q_side;
  hpt_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .in_side   (div_side),
    .out_valid (q_valid),
    .quotient  (quo),
    .out_side  (q_side)
  );

  // Quotient sign and clamp, select divided or plain value
  logic signed [CW-1:0] fin [3];
  logic signed [CW-1:0] plain [3];
  logic [2:0]           qsat;
  always_comb begin
    plain[0] = q_side.res_x;
    plain[1] = q_side.res_y;
    plain[2] = q_side.res_z;
    for (int l = 0; l < 3; l++) begin
      qsat[l] = 1'b0;
      if (!q_side.divided) begin
        fin[l] = plain[l];
      end else if (q_side.neg[l]) begin
        if (quo[l] > Q_LO) begin
          fin[l]  = SAT_LO;
          qsat[l] = 1'b1;
        end else begin
          fin[l] = CW'(-quo[l]);
        end
      end else begin
        if (quo[l] > Q_HI) begin
          fin[l]  = SAT_HI;
          qsat[l] = 1'b1;
        end else begin
          fin[l] = quo[l][CW-1:0];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    result.out_x     <= 32'(fin[0]);
    result.out_y     <= 32'(fin[1]);
    result.out_z     <= 32'(fin[2]);
    result.divided   <= q_side.divided;
    result.saturated <= q_side.sat || (q_side.divided && (qsat != 3'b000));
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

endmodule

### rtl/core/hpt_rowsum.sv
// One matrix row: multiply, add, round toward zero and saturate over four stages.
module hpt_rowsum (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  logic                                      translate,
  input  logic signed [hpt_pkg::COEF_WIDTH-1:0]     coef [4],
  input  logic signed [hpt_pkg::COORD_WIDTH-1:0]    v [3],
  output hpt_pkg::hpt_row_t                         row
);

  localparam int PW = hpt_pkg::PROD_WIDTH;
  localparam int SW = hpt_pkg::SUM_WIDTH;
  localparam int CW = hpt_pkg::COORD_WIDTH;
  localparam int FB = hpt_pkg::FRAC_BITS;

  localparam logic signed [SW-1:0] RND_BIAS = SW'((64'(1) << FB) - 64'(1));
  localparam logic signed [SW-1:0] SAT_HI   = SW'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);

  logic signed [PW-1:0] p0, p1, p2;
  logic signed [SW-1:0] tr;
  logic signed [SW-1:0] a, b;
  logic signed [SW-1:0] s;
  logic signed [SW-1:0] rnd, sh;
  logic [2:0]           vld;
  logic                 row_valid;
  logic                 row_sat;
  logic signed [CW-1:0] row_value;

  // Stage 1: products and translation term
  always_ff @(posedge clk) begin
    p0 <= coef[0] * v[0];
    p1 <= coef[1] * v[1];
    p2 <= coef[2] * v[2];
    tr <= translate ? (SW'(coef[3]) <<< FB) : '0;
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    a <= SW'(p0) + SW'(p1);
    b <= SW'(p2) + tr;
  end

  // Stage 3: full sum
  always_ff @(posedge clk) begin
    s <= a + b;
  end

  // Truncate toward zero, then clamp to coordinate range
  always_comb begin
    rnd = s + (s[SW-1] ? RND_BIAS : '0);
    sh  = rnd >>> FB;
  end

  // Stage 4: result register
  always_ff @(posedge clk) begin
    if (sh > SAT_HI) begin
      row_value <= SAT_HI[CW-1:0];
      row_sat   <= 1'b1;
    end else if (sh < SAT_LO) begin
      row_value <= SAT_LO[CW-1:0];
      row_sat   <= 1'b1;
    end else begin
      row_value <= sh[CW-1:0];
      row_sat   <= 1'b0;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      row_valid <= 1'b0;
    end else begin
      vld       <= {vld[1:0], in_valid};
      row_valid <= vld[2];
    end
  end

  assign row.valid = row_valid;
  assign row.sat   = row_sat;
  assign row.value = row_value;

endmodule

### rtl/core/hpt_divider.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module hpt_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [hpt_pkg::DVD_WIDTH-1:0]        dividend [3],
  input  logic [hpt_pkg::COORD_WIDTH-1:0]      divisor,
  input  hpt_pkg::hpt_side_t                   in_side,
  output logic                                 out_valid,
  output logic [hpt_pkg::DVD_WIDTH-1:0]        quotient [3],
  output hpt_pkg::hpt_side_t                   out_side
);

  localparam int DW = hpt_pkg::DVD_WIDTH;
  localparam int CW = hpt_pkg::COORD_WIDTH;

  logic [CW-1:0]      rem  [1:DW][3];
  logic [DW-1:0]      quo  [1:DW][3];
  logic [DW-1:0]      dvd  [1:DW][3];
  logic [CW-1:0]      dsr  [1:DW];
  hpt_pkg::hpt_side_t side [1:DW];
  logic               vld  [1:DW];

  // One stage per quotient bit
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [CW-1:0]      dsr_in;
    hpt_pkg::hpt_side_t side_in;
    logic               vld_in;

    // Stage inputs: module inputs for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign dsr_in  = divisor;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign dsr_in  = dsr[k];
      assign side_in = side[k];
      assign vld_in  = vld[k];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW-1:0] r_in;
      logic [DW-1:0] q_in;
      logic [DW-1:0] d_in;
      logic [CW:0]   trial;
      logic          ge;
      if (k == 0) begin : g_first
        assign r_in = '0;
        assign q_in = '0;
        assign d_in = dividend[l];
      end else begin : g_next
        assign r_in = rem[k][l];
        assign q_in = quo[k][l];
        assign d_in = dvd[k][l];
      end
      always_comb begin
        trial = {r_in, d_in[DW-1]};
        ge    = trial >= {1'b0, dsr_in};
      end
      always_ff @(posedge clk) begin
        rem[k+1][l] <= ge ? CW'(trial - {1'b0, dsr_in}) : trial[CW-1:0];
        quo[k+1][l] <= {q_in[DW-2:0], ge};
        dvd[k+1][l] <= d_in << 1;
      end
    end
    always_ff @(posedge clk) begin
      dsr[k+1]  <= dsr_in;
      side[k+1] <= side_in;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quotient[l] = quo[DW][l];
    end
    out_side  = side[DW];
    out_valid = vld[DW];
  end

endmodule
